FILE: hdl/potts_metropolis_update_unit_assert.svh
// Assertion macros shared by the Potts update unit RTL.
`ifndef POTTS_METROPOLIS_UPDATE_UNIT_ASSERT_SVH
`define POTTS_METROPOLIS_UPDATE_UNIT_ASSERT_SVH

// Property checked at every rising clk edge outside reset.
`define PMU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// When pre holds, post must hold in the next cycle.
`define PMU_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

FILE: hdl/pmu_pkg.sv
// Shared types, codes and constants of the Potts Metropolis update unit.
`default_nettype none

package pmu_pkg;

  // Default lattice geometry.
  localparam int unsigned SIDE_DEFAULT      = 512;
  localparam int unsigned SPIN_BITS_DEFAULT = 4;

  // Fixed payload field widths.
  localparam int unsigned FUNC_W      = 2;
  localparam int unsigned COORD_W     = 9;
  localparam int unsigned FIELD_SPIN_W = 4;
  localparam int unsigned DRAW_W      = 32;
  localparam int unsigned NS_W        = 4;
  localparam int unsigned DH_W        = 4;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned MAX_COORD_W = 12;

  // Operation codes.
  typedef logic [FUNC_W-1:0] func_t;
  localparam func_t FUNC_UPDATE = 2'd0;
  localparam func_t FUNC_WRITE  = 2'd1;
  localparam func_t FUNC_READ   = 2'd2;

  // Configuration register indexes.
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_NUM_STATES = 3'd0;
  localparam cfg_idx_t REG_PROB_ONE   = 3'd1;
  localparam cfg_idx_t REG_PROB_TWO   = 3'd2;
  localparam cfg_idx_t REG_PROB_THREE = 3'd3;
  localparam cfg_idx_t REG_PROB_FOUR  = 3'd4;

  // Configuration reset values.
  localparam logic [NS_W-1:0]   NUM_STATES_RST = 4'd3;
  localparam logic [DRAW_W-1:0] PROB_ONE_RST   = 32'd1571958030;
  localparam logic [DRAW_W-1:0] PROB_TWO_RST   = 32'd575525617;
  localparam logic [DRAW_W-1:0] PROB_THREE_RST = 32'd210609431;
  localparam logic [DRAW_W-1:0] PROB_FOUR_RST  = 32'd77090627;

  // Sequencer states.
  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_ADDR   = 7'b0000010,
    ST_RD0    = 7'b0000100,
    ST_RD1    = 7'b0001000,
    ST_RD2    = 7'b0010000,
    ST_RD3    = 7'b0100000,
    ST_DECIDE = 7'b1000000
  } state_t;

  // Lane enables for the shared neighbor compare unit.
  typedef struct packed {
    logic use_a;
    logic use_b;
  } cmp_ctl_t;

  // Reduces a coordinate modulo side with a short chain of conditional
  // subtractions; valid for side of four and above.
  function automatic logic [MAX_COORD_W-1:0] coord_mod(input logic [COORD_W-1:0] v,
                                                       input int unsigned side);
    logic [19:0] r;
    logic [19:0] s;
    r = 20'(v);
    for (int k = 6; k >= 0; k--) begin
      s = 20'(side) << k;
      if (r >= s) begin
        r = r - s;
      end
    end
    return r[MAX_COORD_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: hdl/pmu_if.sv
// Valid/ready channel interfaces for requests, results and configuration.
`default_nettype none

interface pmu_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [pmu_pkg::FUNC_W-1:0]           func;
  logic [pmu_pkg::COORD_W-1:0]          site_x;
  logic [pmu_pkg::COORD_W-1:0]          site_y;
  logic [pmu_pkg::FIELD_SPIN_W-1:0]     spin_value;
  logic [pmu_pkg::DRAW_W-1:0]           random_draw;

  modport source (output valid, func, site_x, site_y, spin_value, random_draw,
                  input ready);
  modport sink (input valid, func, site_x, site_y, spin_value, random_draw,
                output ready);
endinterface

interface pmu_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [pmu_pkg::FIELD_SPIN_W-1:0]     site_value;
  logic [pmu_pkg::FIELD_SPIN_W-1:0]     previous_value;
  logic                                 accepted;
  logic signed [pmu_pkg::DH_W-1:0]      energy_change;

  modport source (output valid, site_value, previous_value, accepted, energy_change,
                  input ready);
  modport sink (input valid, site_value, previous_value, accepted, energy_change,
                output ready);
endinterface

interface pmu_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [pmu_pkg::CFG_IDX_W-1:0]        index;
  logic [pmu_pkg::CFG_DATA_W-1:0]       data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hdl/pmu_spin_ram.sv
// Lattice spin memory: one write port and two registered read ports.
`default_nettype none

module pmu_spin_ram #(
  parameter int unsigned DEPTH = pmu_pkg::SIDE_DEFAULT * pmu_pkg::SIDE_DEFAULT,
  parameter int unsigned AW    = $clog2(DEPTH),
  parameter int unsigned DW    = pmu_pkg::SPIN_BITS_DEFAULT
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] wa,
  input  wire logic [DW-1:0] wd,
  input  wire logic [AW-1:0] ra_a,
  input  wire logic [AW-1:0] ra_b,
  output logic      [DW-1:0] rd_a,
  output logic      [DW-1:0] rd_b
);

  logic [DW-1:0] mem [DEPTH];

  // Write port and both read ports; read data is registered and appears in the next cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_a <= mem[ra_a];
    rd_b <= mem[ra_b];
  end

endmodule

`default_nettype wire

FILE: hdl/pmu_cmp_unit.sv
// Shared neighbor compare unit: per lane, disagreement with the candidate
// minus disagreement with the current color.
`default_nettype none

module pmu_cmp_unit #(
  parameter int unsigned SPIN_BITS = pmu_pkg::SPIN_BITS_DEFAULT
) (
  input  wire pmu_pkg::cmp_ctl_t       ctl,
  input  wire logic [SPIN_BITS-1:0]    val_a,
  input  wire logic [SPIN_BITS-1:0]    val_b,
  input  wire logic [SPIN_BITS-1:0]    cand,
  input  wire logic [SPIN_BITS-1:0]    cur,
  output logic signed [2:0]            delta
);

  logic signed [2:0] da;
  logic signed [2:0] db;

  // Each enabled lane contributes -1, 0 or +1 to the energy change.
  always_comb begin
    da = 3'sd0;
    db = 3'sd0;
    if (ctl.use_a) begin
      da = $signed({2'b00, val_a != cand}) - $signed({2'b00, val_a != cur});
    end
    if (ctl.use_b) begin
      db = $signed({2'b00, val_b != cand}) - $signed({2'b00, val_b != cur});
    end
    delta = da + db;
  end

endmodule

`default_nettype wire

FILE: hdl/potts_metropolis_update_unit.sv
// Top level of the Potts model Metropolis update unit.
//
// Usage: items arrive on req (func, site_x, site_y, spin_value, random_draw)
// and one result per item leaves on rsp (site_value, previous_value,
// accepted, energy_change). Both are valid/ready channels; an item moves at
// a rising edge with valid and ready high. cfg writes the five registers by
// index and is always ready; the user must use it only while the block is
// idle, which the block does not enforce. An item is taken only when idle
// and the next waits until the last result is registered. The sequence is
// an address stage, five lattice reads (center and four torus neighbors)
// through the two RAM read ports and a decision state; the shared compare
// unit folds in one or two neighbors per read cycle.
// Reset clears the sequencer, the output valid and restores the register
// defaults; the lattice is not cleared and each site must be written before
// it is read. When rsp stalls, the finished result waits in the output
// register; the next item is still accepted and runs until its decision
// cycle, where it waits for the output register to free.
`default_nettype none
`include "potts_metropolis_update_unit_assert.svh"

module potts_metropolis_update_unit #(
  parameter int unsigned SIDE      = pmu_pkg::SIDE_DEFAULT,
  parameter int unsigned SPIN_BITS = pmu_pkg::SPIN_BITS_DEFAULT
) (
  input  wire logic  clk,
  input  wire logic  rst,
  pmu_cfg_if.sink    cfg,
  pmu_in_if.sink     req,
  pmu_out_if.source  rsp
);

  localparam int unsigned CW    = $clog2(SIDE);
  localparam int unsigned DEPTH = SIDE * SIDE;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned SW    = (SPIN_BITS > pmu_pkg::FIELD_SPIN_W) ?
                                  SPIN_BITS : pmu_pkg::FIELD_SPIN_W;
  localparam int unsigned LAST_ROW_BASE = (SIDE - 1) * SIDE;

  pmu_pkg::state_t state;
  pmu_pkg::state_t state_next;

  // Configuration registers.
  logic [pmu_pkg::NS_W-1:0]   num_states;
  logic [pmu_pkg::DRAW_W-1:0] prob_one;
  logic [pmu_pkg::DRAW_W-1:0] prob_two;
  logic [pmu_pkg::DRAW_W-1:0] prob_three;
  logic [pmu_pkg::DRAW_W-1:0] prob_four;

  // Item registers.
  pmu_pkg::func_t             func_q;
  logic [CW-1:0]              x_q;
  logic [CW-1:0]              y_q;
  logic [SPIN_BITS-1:0]       cand_q;
  logic [pmu_pkg::DRAW_W-1:0] draw_q;
  logic [AW-1:0]              row_base;
  logic [SPIN_BITS-1:0]       prev_q;
  logic signed [pmu_pkg::DH_W-1:0] dh;

  logic [pmu_pkg::MAX_COORD_W-1:0] x_full;
  logic [pmu_pkg::MAX_COORD_W-1:0] y_full;
  logic [SW-1:0]              spin_ext;
  logic                       accept_item;

  logic [CW-1:0]              x_last;
  logic [CW-1:0]              xl;
  logic [CW-1:0]              xr;
  logic [AW-1:0]              row_up;
  logic [AW-1:0]              row_dn;
  logic [AW-1:0]              center_addr;
  logic [AW-1:0]              ra_a;
  logic [AW-1:0]              ra_b;
  logic [SPIN_BITS-1:0]       rd_a;
  logic [SPIN_BITS-1:0]       rd_b;

  pmu_pkg::cmp_ctl_t          cmp_ctl;
  logic [SPIN_BITS-1:0]       cmp_cur;
  logic signed [2:0]          cmp_delta;

  logic                       out_free;
  logic                       in_range;
  logic [pmu_pkg::DRAW_W-1:0] thr;
  logic                       upd_acc;
  logic                       acc;
  logic                       ram_we;
  logic [SPIN_BITS-1:0]       new_site;
  logic [SW-1:0]              new_ext;
  logic [SW-1:0]              prev_ext;
  logic signed [pmu_pkg::DH_W-1:0] dh_out;

  // Configuration writes; indexes beyond the register list are dropped.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_states <= pmu_pkg::NUM_STATES_RST;
      prob_one   <= pmu_pkg::PROB_ONE_RST;
      prob_two   <= pmu_pkg::PROB_TWO_RST;
      prob_three <= pmu_pkg::PROB_THREE_RST;
      prob_four  <= pmu_pkg::PROB_FOUR_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        pmu_pkg::REG_NUM_STATES: num_states <= cfg.data[pmu_pkg::NS_W-1:0];
        pmu_pkg::REG_PROB_ONE:   prob_one   <= cfg.data;
        pmu_pkg::REG_PROB_TWO:   prob_two   <= cfg.data;
        pmu_pkg::REG_PROB_THREE: prob_three <= cfg.data;
        pmu_pkg::REG_PROB_FOUR:  prob_four  <= cfg.data;
        default: ;
      endcase
    end
  end

  // Input capture with coordinates reduced onto the torus.
  assign req.ready   = (state == pmu_pkg::ST_IDLE);
  assign accept_item = req.valid && req.ready;
  assign x_full      = pmu_pkg::coord_mod(req.site_x, SIDE);
  assign y_full      = pmu_pkg::coord_mod(req.site_y, SIDE);
  assign spin_ext    = SW'(req.spin_value);

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      pmu_pkg::ST_IDLE:   if (req.valid) state_next = pmu_pkg::ST_ADDR;
      pmu_pkg::ST_ADDR:   state_next = pmu_pkg::ST_RD0;
      pmu_pkg::ST_RD0:    state_next = pmu_pkg::ST_RD1;
      pmu_pkg::ST_RD1:    state_next = pmu_pkg::ST_RD2;
      pmu_pkg::ST_RD2:    state_next = pmu_pkg::ST_RD3;
      pmu_pkg::ST_RD3:    state_next = pmu_pkg::ST_DECIDE;
      pmu_pkg::ST_DECIDE: if (out_free) state_next = pmu_pkg::ST_IDLE;
      default:            state_next = pmu_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pmu_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Neighbor coordinates and row bases with torus wrap.
  assign x_last      = CW'(SIDE - 1);
  assign xl          = (x_q == '0) ? x_last : x_q - 1'b1;
  assign xr          = (x_q == x_last) ? '0 : x_q + 1'b1;
  assign row_up      = (y_q == '0) ? row_base + AW'(LAST_ROW_BASE) : row_base - AW'(SIDE);
  assign row_dn      = (y_q == x_last) ? '0 : row_base + AW'(SIDE);
  assign center_addr = row_base + AW'(x_q);

  // Read address selection: center and left, then right and up, then down.
  always_comb begin
    ra_a = center_addr;
    ra_b = center_addr;
    case (state)
      pmu_pkg::ST_RD0: begin
        ra_a = center_addr;
        ra_b = row_base + AW'(xl);
      end
      pmu_pkg::ST_RD1: begin
        ra_a = row_base + AW'(xr);
        ra_b = row_up + AW'(x_q);
      end
      pmu_pkg::ST_RD2: begin
        ra_a = row_dn + AW'(x_q);
        ra_b = center_addr;
      end
      default: begin
        ra_a = center_addr;
        ra_b = center_addr;
      end
    endcase
  end

  pmu_spin_ram #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (SPIN_BITS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .wa   (center_addr),
    .wd   (cand_q),
    .ra_a (ra_a),
    .ra_b (ra_b),
    .rd_a (rd_a),
    .rd_b (rd_b)
  );

  // Compare lanes per read cycle; the center arrives with the left neighbor.
  always_comb begin
    cmp_ctl = '0;
    case (state)
      pmu_pkg::ST_RD1: cmp_ctl = '{use_a: 1'b0, use_b: 1'b1};
      pmu_pkg::ST_RD2: cmp_ctl = '{use_a: 1'b1, use_b: 1'b1};
      pmu_pkg::ST_RD3: cmp_ctl = '{use_a: 1'b1, use_b: 1'b0};
      default:         cmp_ctl = '0;
    endcase
  end

  assign cmp_cur = (state == pmu_pkg::ST_RD1) ? rd_a : prev_q;

  pmu_cmp_unit #(
    .SPIN_BITS (SPIN_BITS)
  ) u_cmp (
    .ctl   (cmp_ctl),
    .val_a (rd_a),
    .val_b (rd_b),
    .cand  (cand_q),
    .cur   (cmp_cur),
    .delta (cmp_delta)
  );

  // Item registers, row base and energy accumulation.
  always_ff @(posedge clk) begin
    if (accept_item) begin
      func_q <= req.func;
      x_q    <= x_full[CW-1:0];
      y_q    <= y_full[CW-1:0];
      cand_q <= spin_ext[SPIN_BITS-1:0];
      draw_q <= req.random_draw;
      dh     <= '0;
    end
    if (state == pmu_pkg::ST_ADDR) begin
      row_base <= AW'(y_q) * AW'(SIDE);
    end
    if (state == pmu_pkg::ST_RD1) begin
      prev_q <= rd_a;
    end
    if (cmp_ctl.use_a || cmp_ctl.use_b) begin
      dh <= dh + {cmp_delta[2], cmp_delta};
    end
  end

  // Decision: threshold for uphill moves, write-back and result.
  assign out_free = !rsp.valid || rsp.ready;
  assign in_range = SW'(cand_q) < SW'(num_states);

  always_comb begin
    case (dh)
      4'sd1:   thr = prob_one;
      4'sd2:   thr = prob_two;
      4'sd3:   thr = prob_three;
      default: thr = prob_four;
    endcase
  end

  assign upd_acc  = in_range && ((dh <= 4'sd0) || (draw_q < thr));
  assign acc      = (func_q == pmu_pkg::FUNC_UPDATE) ? upd_acc
                                                     : (func_q == pmu_pkg::FUNC_WRITE);
  assign ram_we   = (state == pmu_pkg::ST_DECIDE) && out_free && acc;
  assign new_site = acc ? cand_q : prev_q;
  assign new_ext  = SW'(new_site);
  assign prev_ext = SW'(prev_q);
  assign dh_out   = ((func_q == pmu_pkg::FUNC_UPDATE) && in_range) ? dh : 4'sd0;

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if ((state == pmu_pkg::ST_DECIDE) && out_free) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == pmu_pkg::ST_DECIDE) && out_free) begin
      rsp.site_value     <= new_ext[pmu_pkg::FIELD_SPIN_W-1:0];
      rsp.previous_value <= prev_ext[pmu_pkg::FIELD_SPIN_W-1:0];
      rsp.accepted       <= acc;
      rsp.energy_change  <= dh_out;
    end
  end

  // Assertions. Writes and reads may sit next to sites that were never
  // written, so the energy range is only checked for updates.
  `PMU_ASSERT(a_we_only_update_or_write,
              ram_we |-> (func_q == pmu_pkg::FUNC_UPDATE || func_q == pmu_pkg::FUNC_WRITE),
              "lattice written by a read item")
  `PMU_ASSERT(a_dh_in_range,
              ((state == pmu_pkg::ST_DECIDE) && (func_q == pmu_pkg::FUNC_UPDATE)) |->
              (int'(dh) >= -4 && int'(dh) <= 4),
              "energy change outside -4..4")
  `PMU_ASSERT_NEXT(a_accept_starts_sequence, accept_item,
                   state == pmu_pkg::ST_ADDR,
                   "accepted item did not start the sequence")
  `PMU_ASSERT(a_rsp_from_decide,
              $rose(rsp.valid) |-> ($past(state) == pmu_pkg::ST_DECIDE),
              "result raised outside the decision cycle")

endmodule

`default_nettype wire
